// ===== rtl/woi_pkg.sv =====
// Shared types, constants and the arctangent table for the wheel odometry integrator.
package woi_pkg;

    localparam int CS_W    = 34;
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 49;
    localparam int DIV_Q_W = 30;
    localparam int DIV_R_W = 20;
    localparam int RECIP_SH = 34;

    localparam logic [7:0]             FRAME_MARK   = 8'h00;
    localparam logic signed [CS_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic [DIV_R_W:0]       US_PER_S     = 21'd1000000;
    localparam logic [MUL_B_W-1:0]     RECIP_1M     = 33'd2251799813;
    localparam logic [MUL_B_W-1:0]     ANG_SCALE    = 33'd43748;
    localparam logic [3:0]             MSTEP_LAST   = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_MUL,
        ST_DIVX,
        ST_DIVY,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DS_RECIP,
        DS_BACK,
        DS_FIX
    } div_step_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/woi_f2q.sv =====
// IEEE single to saturating Q16.16 converter.
module woi_f2q
    import woi_pkg::*;
(
    input  logic [31:0]        bits,
    output logic signed [31:0] q
);

    always_comb
    begin
        logic        neg;
        logic [7:0]  e;
        logic [23:0] m;
        logic [32:0] mag;
        logic [7:0]  n;
        neg = bits[31];
        e   = bits[30:23];
        m   = {1'b0, bits[22:0]};
        mag = '0;
        n   = '0;
        q   = '0;
        if (e == 8'hFF)
        begin
            if (m[22:0] == 23'd0)
                q = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            if (e == 8'd0)
                e = 8'd1;
            else
                m[23] = 1'b1;
            if (e > 8'd142)
                mag = 33'h1_0000_0000;
            else if (e >= 8'd134)
                mag = {9'b0, m} << (e - 8'd134);
            else
            begin
                n = 8'd134 - e;
                mag = (n >= 8'd32) ? 33'd0 : ({9'b0, m} >> n);
            end
            if (neg)
                q = (mag > 33'h0_8000_0000) ? 32'sh80000000 : 32'(~mag + 33'd1);
            else
                q = (mag > 33'h0_7FFF_FFFF) ? 32'sh7FFFFFFF : mag[31:0];
        end
    end

endmodule

// ===== rtl/woi_cordic.sv =====
// Iterative CORDIC producing cos and sin of a binary angle, one rotation per cycle.
module woi_cordic
    import woi_pkg::*;
#(
    parameter int STEPS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [31:0]            ang,
    output logic                   done,
    output logic signed [CS_W-1:0] cos_o,
    output logic signed [CS_W-1:0] sin_o
);

    localparam int CNT_W = $clog2(STEPS + 1);

    logic signed [CS_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next, done_reg, done_next, flip_reg, flip_next;
    logic [31:0]            ang_q, ang_f;
    logic [4:0]             idx;
    logic signed [CS_W-1:0] dx, dy, at;

    assign ang_q = ang + 32'h40000000;
    assign ang_f = ang ^ {ang_q[31], 31'b0};
    assign idx   = 5'(cnt_reg);
    assign dx    = y_reg >>> idx;
    assign dy    = x_reg >>> idx;
    assign at    = {2'b00, atan_lut(idx)};

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        if (start)
        begin
            flip_next = ang_q[31];
            x_next    = CORDIC_START;
            y_next    = '0;
            z_next    = {{2{ang_f[31]}}, ang_f};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CS_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign done  = done_reg;
    assign cos_o = flip_reg ? -x_reg : x_reg;
    assign sin_o = flip_reg ? -y_reg : y_reg;

endmodule

// ===== rtl/woi_mul.sv =====
// Shared signed multiplier with registered product.
module woi_mul
    import woi_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/woi_div.sv =====
// Divider by one million: reciprocal multiply, back-multiply and one correction step.
module woi_div
    import woi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    output logic               done,
    output logic [DIV_Q_W-1:0] quot
);

    logic [DIV_N_W-1:0]        n_reg, n_next;
    logic [DIV_Q_W-1:0]        q_reg, q_next;
    div_step_t                 step_reg, step_next;
    logic                      busy_reg, busy_next, done_reg, done_next;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [DIV_Q_W-1:0]        q_est;
    logic [DIV_N_W:0]          rem;

    woi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    // estimate is low by at most one; remainder stays below 2 * 10^6
    assign q_est = mul_p[RECIP_SH+DIV_Q_W-1:RECIP_SH];
    assign rem   = {1'b0, n_reg} - mul_p[DIV_N_W:0];

    always_comb
    begin
        n_next    = n_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mul_a     = {3'b000, n_reg[DIV_N_W-1:DIV_N_W-32]};
        mul_b     = RECIP_1M;
        if (start)
        begin
            n_next    = dividend;
            step_next = DS_RECIP;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                DS_RECIP:
                begin
                    step_next = DS_BACK;
                end
                DS_BACK:
                begin
                    mul_a     = {5'b00000, q_est};
                    mul_b     = {12'b0, US_PER_S};
                    q_next    = q_est;
                    step_next = DS_FIX;
                end
                DS_FIX:
                begin
                    if (rem >= {29'b0, US_PER_S})
                        q_next = q_reg + 1'b1;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= DS_RECIP;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/wheel_odometry_integrator.sv =====
// Top level of the wheel odometry integrator: sequencer, state and stream ports.
//
// One input transfer carries a whole speed frame; one output transfer carries
// the updated pose, the converted speeds and a frame_ok flag on tuser.
// A frame with nonzero head or tail byte leaves the pose alone and reports
// zero speeds with frame_ok low once the output state loads the output register.
// A good frame runs the CORDIC rotations, the steps on the
// shared multiplier, two passes of the reciprocal divider by 10^6
// and a load of the output register before m_tvalid rises.
// s_tready is high only while the block is idle; one frame is in flight, so
// a new frame is taken only after the last result has left the output state.
// A finished result sits in the output register until m_tready takes it;
// a following frame may be taken meanwhile, but its result waits in the
// output state and no further frame is taken until the register is free.
// Reset clears position, heading and all control; no output is valid.
module wheel_odometry_integrator
    import woi_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // head_byte, tail_byte, vx_bits, vy_bits, wz_bits, dt_us
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, heading, vel_x, vel_y, yaw_rate
    output logic [191:0] m_tdata,
    // frame_ok
    output logic         m_tuser
);

    state_t state_reg, state_next;
    logic [3:0] mstep_reg, mstep_next;

    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next, wz_reg, wz_next;
    logic signed [31:0] vx_c, vy_c, wz_c;
    logic [15:0]        dt_reg, dt_next;
    logic               ok_reg, ok_next;
    logic signed [63:0] acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic [31:0]        kd_reg, kd_next;
    logic signed [MUL_P_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [31:0]        x_reg, x_next, y_reg, y_next, yaw_reg, yaw_next;
    logic               mv_reg, mv_next, mu_reg, mu_next;
    logic [191:0]       md_reg, md_next;

    logic                      accept, frame_good;
    logic                      cordic_start, cordic_done;
    logic signed [CS_W-1:0]    cos_v, sin_v;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic                      div_start, div_done;
    logic [DIV_N_W-1:0]        div_n;
    logic [DIV_Q_W-1:0]        div_q;
    logic [MUL_P_W-1:0]        mag_x, mag_y;

    function automatic logic [31:0] sat_add(input logic [31:0] p, input logic neg,
                                            input logic [DIV_Q_W-1:0] q);
        logic [32:0] d, s;
        d = neg ? (33'd0 - 33'(q)) : 33'(q);
        s = {p[31], p} + d;
        if (s[32] != s[31])
            return s[32] ? 32'h80000000 : 32'h7FFFFFFF;
        return s[31:0];
    endfunction

    woi_f2q u_f2q_vx (.bits(s_tdata[47:16]),  .q(vx_c));
    woi_f2q u_f2q_vy (.bits(s_tdata[79:48]),  .q(vy_c));
    woi_f2q u_f2q_wz (.bits(s_tdata[111:80]), .q(wz_c));

    woi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cordic_start), .ang(yaw_reg),
        .done(cordic_done), .cos_o(cos_v), .sin_o(sin_v)
    );

    woi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    woi_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n),
        .done(div_done), .quot(div_q)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign frame_good = (s_tdata[7:0] == FRAME_MARK) && (s_tdata[15:8] == FRAME_MARK);
    assign cordic_start = accept && frame_good;
    assign mag_x = px_reg[MUL_P_W-1] ? -px_reg : px_reg;
    assign mag_y = py_reg[MUL_P_W-1] ? -py_reg : py_reg;
    assign div_n = (state_reg == ST_MUL) ? mag_x[DIV_N_W-1:0] : mag_y[DIV_N_W-1:0];
    assign div_start = ((state_reg == ST_MUL) && (mstep_reg == MSTEP_LAST))
                       || ((state_reg == ST_DIVX) && div_done);

    always_comb
    begin
        mul_a = {{3{vx_reg[31]}}, vx_reg};
        mul_b = MUL_B_W'(cos_v);
        case (mstep_reg)
            4'd0:
            begin
                mul_a = {{3{vx_reg[31]}}, vx_reg};
                mul_b = MUL_B_W'(cos_v);
            end
            4'd1:
            begin
                mul_a = {{3{vy_reg[31]}}, vy_reg};
                mul_b = MUL_B_W'(sin_v);
            end
            4'd2:
            begin
                mul_a = {{3{vx_reg[31]}}, vx_reg};
                mul_b = MUL_B_W'(sin_v);
            end
            4'd3:
            begin
                mul_a = {{3{vy_reg[31]}}, vy_reg};
                mul_b = MUL_B_W'(cos_v);
            end
            4'd4:
            begin
                mul_a = {19'd0, dt_reg};
                mul_b = ANG_SCALE;
            end
            4'd5:
            begin
                mul_a = {acc_a_reg[63], acc_a_reg[63:30]};
                mul_b = {17'd0, dt_reg};
            end
            4'd6:
            begin
                mul_a = {acc_b_reg[63], acc_b_reg[63:30]};
                mul_b = {17'd0, dt_reg};
            end
            4'd7:
            begin
                mul_a = {{3{wz_reg[31]}}, wz_reg};
                mul_b = {1'b0, kd_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mstep_next = mstep_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        wz_next    = wz_reg;
        dt_next    = dt_reg;
        ok_next    = ok_reg;
        acc_a_next = acc_a_reg;
        acc_b_next = acc_b_reg;
        kd_next    = kd_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        yaw_next   = yaw_reg;
        mv_next    = mv_reg && !m_tready;
        mu_next    = mu_reg;
        md_next    = md_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ok_next    = frame_good;
                    vx_next    = frame_good ? vx_c : 32'sd0;
                    vy_next    = frame_good ? vy_c : 32'sd0;
                    wz_next    = frame_good ? wz_c : 32'sd0;
                    dt_next    = s_tdata[127:112];
                    state_next = frame_good ? ST_ROT : ST_OUT;
                end
            end
            ST_ROT:
            begin
                if (cordic_done)
                begin
                    mstep_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mstep_next = mstep_reg + 1'b1;
                case (mstep_reg)
                    4'd1: acc_a_next = 64'(mul_p);
                    4'd2: acc_a_next = acc_a_reg - 64'(mul_p);
                    4'd3: acc_b_next = 64'(mul_p);
                    4'd4: acc_b_next = acc_b_reg + 64'(mul_p);
                    4'd5: kd_next    = mul_p[31:0];
                    4'd6: px_next    = mul_p;
                    4'd7: py_next    = mul_p;
                    4'd8:
                    begin
                        yaw_next   = yaw_reg + mul_p[53:22];
                        state_next = ST_DIVX;
                    end
                    default: ;
                endcase
            end
            ST_DIVX:
            begin
                if (div_done)
                begin
                    x_next     = sat_add(x_reg, px_reg[MUL_P_W-1], div_q);
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_done)
                begin
                    y_next     = sat_add(y_reg, py_reg[MUL_P_W-1], div_q);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mu_next    = ok_reg;
                    md_next    = {wz_reg, vy_reg, vx_reg, yaw_reg, y_reg, x_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mstep_reg <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            yaw_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mstep_reg <= mstep_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            yaw_reg   <= yaw_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        wz_reg    <= wz_next;
        dt_reg    <= dt_next;
        ok_reg    <= ok_next;
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
        kd_reg    <= kd_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        mu_reg    <= mu_next;
        md_reg    <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = mu_reg;
    assign m_tdata  = md_reg;

    a_cordic_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> state_reg == ST_ROT)
        else $error("cordic finished outside rotation phase");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVX || state_reg == ST_DIVY))
        else $error("divider finished outside division phase");

    a_bad_frame_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tdata[191:96] == '0)
        else $error("rejected frame reports nonzero speed");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second frame taken while one is in flight");

endmodule
